// ----- hdl/rbmc_pkg.sv -----
`default_nettype none

package rbmc_pkg;

   localparam int CH_N      = 4;
   localparam int CH_W      = 8;
   localparam int LANE_W    = CH_W + 1;
   localparam int TOT_W     = CH_W + 2;
   localparam int CFG_W     = 13;
   localparam int LVL_CFG_W = 4;
   localparam int LEVEL_W   = 4;
   localparam int COORD_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIP_LEVELS  = 2'd2;

   typedef logic [CH_N-1:0][CH_W-1:0]   pix_type;
   typedef logic [CH_N-1:0][LANE_W-1:0] lanes_type;

   typedef struct packed {
      logic load;
      logic feed;
      logic avg;
   } cmd_type;

   typedef struct packed {
      logic run;
      logic prod;
      logic more;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_AVG,
      ST_SEND_MID,
      ST_SEND_LAST
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/rbmc_if.sv -----
`default_nettype none

interface rbmc_req_if;
   logic                      valid;
   logic                      ready;
   logic [rbmc_pkg::CH_W-1:0] red;
   logic [rbmc_pkg::CH_W-1:0] green;
   logic [rbmc_pkg::CH_W-1:0] blue;
   logic [rbmc_pkg::CH_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

interface rbmc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rbmc_pkg::LEVEL_W-1:0] level;
   logic [rbmc_pkg::COORD_W-1:0] col;
   logic [rbmc_pkg::COORD_W-1:0] row;
   logic [rbmc_pkg::CH_W-1:0]    out_red;
   logic [rbmc_pkg::CH_W-1:0]    out_green;
   logic [rbmc_pkg::CH_W-1:0]    out_blue;
   logic [rbmc_pkg::CH_W-1:0]    out_alpha;
   logic                         last;

   modport source (output valid, output level, output col, output row, output out_red,
                   output out_green, output out_blue, output out_alpha, output last,
                   input ready);
   modport sink (input valid, input level, input col, input row, input out_red,
                 input out_green, input out_blue, input out_alpha, input last,
                 output ready);
endinterface

`default_nettype wire

// ----- hdl/rbmc_ctrl.sv -----
`default_nettype none

module rbmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_last,
   input  rbmc_pkg::status_type   status,
   output rbmc_pkg::cmd_type      cmd
);
   import rbmc_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;   // a finished pixel sits in the output register

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.run) begin
                  state_in = ST_FEED;
               end
            end
         end
         ST_FEED: begin
            cmd.feed = 1'b1;
            // the previous pixel is last only if this level produces nothing
            if (status.prod) begin
               state_in = pend_ff ? ST_SEND_MID : ST_AVG;
            end else begin
               state_in = pend_ff ? ST_SEND_LAST : ST_IDLE;
            end
         end
         ST_AVG: begin
            cmd.avg  = 1'b1;
            pend_in  = 1'b1;
            state_in = status.more ? ST_FEED : ST_SEND_LAST;
         end
         ST_SEND_MID: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               pend_in  = 1'b0;
               state_in = ST_AVG;
            end
         end
         ST_SEND_LAST: begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            if (rsp_ready) begin
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/rbmc_dp.sv -----
`default_nettype none

module rbmc_dp #(
   parameter int MAX_SIDE   = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [rbmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbmc_pkg::CFG_W-1:0]         csr_wdata,
   input  rbmc_pkg::pix_type                  in_pix,
   input  rbmc_pkg::cmd_type                  cmd,
   output rbmc_pkg::status_type               status,
   output logic [rbmc_pkg::LEVEL_W-1:0]       out_level,
   output logic [rbmc_pkg::COORD_W-1:0]       out_col,
   output logic [rbmc_pkg::COORD_W-1:0]       out_row,
   output rbmc_pkg::pix_type                  out_pix
);
   import rbmc_pkg::*;

   localparam int AW  = $clog2(MAX_SIDE);
   localparam int SW  = $clog2(MAX_SIDE + 1);
   localparam int LW  = $clog2(MAX_LEVELS);
   localparam int LCW = $clog2(MAX_LEVELS + 1);
   localparam int CW  = LCW + 1;
   localparam int IW  = $clog2(MAX_SIDE + MAX_LEVELS) + 1;

   // configuration
   logic [CFG_W-1:0]     width_ff, height_ff;
   logic [LVL_CFG_W-1:0] levels_ff;
   logic                 cfg_hit;
   logic [SW-1:0]        base_w, base_h;
   logic [LCW-1:0]       levels_eff;

   // per-item level walk
   logic [LW-1:0]        k_ff;
   logic [SW-1:0]        pw_ff, ph_ff;
   logic [IW-1:0]        off_ff;
   pix_type              pix_ff;

   // per-level builder state
   logic [AW-1:0]        col_pos_ff [MAX_LEVELS];
   logic [AW-1:0]        row_pos_ff [MAX_LEVELS];
   lanes_type            cps_ff     [MAX_LEVELS];

   // feed results held for the averaging step
   lanes_type            hs_ff;
   logic                 ph_one_ff;
   logic [AW-1:0]        cx_ff, cy_ff;
   logic                 rd_zero_ff;
   lanes_type            rdata_ff;
   lanes_type            row_sum_mem_ff [MAX_SIDE];

   // output register
   logic [LEVEL_W-1:0]   level_ff;
   logic [COORD_W-1:0]   col_ff, row_ff;
   pix_type              opix_ff;

   // combinational
   logic [AW-1:0]        x, y, cx;
   logic                 col_last, row_last, pw_one, ph_one, hvalid, in_range;
   logic                 mem_wr, mem_rd;
   lanes_type            p, hs, prev;
   logic [IW-1:0]        idx;
   logic [SW-1:0]        next_w, next_h;
   pix_type              avg_pix;
   logic [TOT_W-1:0]     tot [CH_N];

   assign cfg_hit = csr_write_en && (csr_index == CSR_BASE_WIDTH ||
                    csr_index == CSR_BASE_HEIGHT || csr_index == CSR_MIP_LEVELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
         levels_ff <= LVL_CFG_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BASE_WIDTH:  width_ff  <= csr_wdata;
            CSR_BASE_HEIGHT: height_ff <= csr_wdata;
            CSR_MIP_LEVELS:  levels_ff <= csr_wdata[LVL_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         base_w = SW'(1);
      end else if (32'(width_ff) > 32'(MAX_SIDE)) begin
         base_w = SW'(MAX_SIDE);
      end else begin
         base_w = SW'(width_ff);
      end
      if (height_ff == '0) begin
         base_h = SW'(1);
      end else if (32'(height_ff) > 32'(MAX_SIDE)) begin
         base_h = SW'(MAX_SIDE);
      end else begin
         base_h = SW'(height_ff);
      end
      if (32'(levels_ff) > 32'(MAX_LEVELS)) begin
         levels_eff = LCW'(MAX_LEVELS);
      end else begin
         levels_eff = LCW'(levels_ff);
      end
   end

   // feed step of level k
   always_comb begin
      x        = col_pos_ff[k_ff];
      y        = row_pos_ff[k_ff];
      col_last = ((SW+1)'(x) + (SW+1)'(1)) >= (SW+1)'(pw_ff);
      row_last = ((SW+1)'(y) + (SW+1)'(1)) >= (SW+1)'(ph_ff);
      pw_one   = pw_ff == SW'(1);
      ph_one   = ph_ff == SW'(1);
      hvalid   = pw_one || x[0];
      for (int c = 0; c < CH_N; c++) begin
         p[c]  = {1'b0, pix_ff[c]};
         hs[c] = pw_one ? p[c] + p[c] : cps_ff[k_ff][c] + p[c];
      end
      cx       = x >> 1;
      idx      = off_ff + IW'(cx);
      in_range = idx < IW'(MAX_SIDE);
      mem_wr   = cmd.feed && hvalid && !ph_one && !y[0] && in_range;
      mem_rd   = cmd.feed && hvalid && !ph_one && y[0];
   end

   assign status.prod = hvalid && (ph_one || y[0]);
   assign status.run  = levels_eff > LCW'(1);
   assign status.more = (CW'(k_ff) + CW'(1)) < CW'(levels_eff);

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_pos_ff[i] <= '0;
            row_pos_ff[i] <= '0;
            cps_ff[i]     <= '0;
         end
      end else if (cmd.feed) begin
         if (col_last) begin
            col_pos_ff[k_ff] <= '0;
            row_pos_ff[k_ff] <= row_last ? '0 : y + AW'(1);
         end else begin
            col_pos_ff[k_ff] <= x + AW'(1);
         end
         if (!hvalid) begin
            cps_ff[k_ff] <= p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.feed) begin
         hs_ff      <= hs;
         ph_one_ff  <= ph_one;
         cx_ff      <= cx;
         cy_ff      <= y >> 1;
         rd_zero_ff <= !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         row_sum_mem_ff[idx[AW-1:0]] <= hs;
      end
      if (mem_rd) begin
         rdata_ff <= row_sum_mem_ff[idx[AW-1:0]];
      end
   end

   // averaging step
   always_comb begin
      prev = rd_zero_ff ? '0 : rdata_ff;
      for (int c = 0; c < CH_N; c++) begin
         tot[c]     = ph_one_ff ? {hs_ff[c], 1'b0} : TOT_W'(prev[c]) + TOT_W'(hs_ff[c]);
         avg_pix[c] = tot[c][TOT_W-1:2];
      end
      next_w = ((pw_ff >> 1) == '0) ? SW'(1) : pw_ff >> 1;
      next_h = ((ph_ff >> 1) == '0) ? SW'(1) : ph_ff >> 1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         k_ff   <= LW'(1);
         pw_ff  <= base_w;
         ph_ff  <= base_h;
         off_ff <= '0;
         pix_ff <= in_pix;
      end else if (cmd.avg) begin
         k_ff   <= k_ff + LW'(1);
         pw_ff  <= next_w;
         ph_ff  <= next_h;
         off_ff <= off_ff + IW'(next_w);
         pix_ff <= avg_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.avg) begin
         level_ff <= LEVEL_W'(k_ff);
         col_ff   <= COORD_W'(cx_ff);
         row_ff   <= COORD_W'(cy_ff);
         opix_ff  <= avg_pix;
      end
   end

   assign out_level = level_ff;
   assign out_col   = col_ff;
   assign out_row   = row_ff;
   assign out_pix   = opix_ff;

endmodule

`default_nettype wire

// ----- hdl/rgba8_box_mip_chain_top.sv -----
`default_nettype none

// 2x2 box-filter mip chain for an RGBA8 base image streamed in raster order.
// Each accepted base pixel walks levels 1..mip_levels-1 through one shared
// level builder: a level that completes a pixel passes it on to the next.
// When mip_levels is 1 or less a transaction produces no result. Otherwise
// each level takes a feed step and, when it produces a pixel, an averaging
// step; each result waits in a send state until rsp ready is high, the last
// one after a closing feed or when the chain stops at mip_levels-1. The
// single level builder and the single port of the row pair-sum RAM set
// this order. The RAM needs no clearing pass after reset. Any register write
// restarts the image at pixel (0,0) and must be done while the block is idle.

module rgba8_box_mip_chain_top #(
   parameter int MAX_SIDE   = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [rbmc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbmc_pkg::CFG_W-1:0]      csr_wdata,
   rbmc_req_if.sink                        req_bus,
   rbmc_rsp_if.source                      rsp_bus
);
   import rbmc_pkg::*;

   cmd_type    cmd;
   status_type status;
   pix_type    in_pix, out_pix;

   assign in_pix[0] = req_bus.red;
   assign in_pix[1] = req_bus.green;
   assign in_pix[2] = req_bus.blue;
   assign in_pix[3] = req_bus.alpha;

   rbmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_last  (rsp_bus.last),
      .status    (status),
      .cmd       (cmd)
   );

   rbmc_dp #(
      .MAX_SIDE   (MAX_SIDE),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_pix       (in_pix),
      .cmd          (cmd),
      .status       (status),
      .out_level    (rsp_bus.level),
      .out_col      (rsp_bus.col),
      .out_row      (rsp_bus.row),
      .out_pix      (out_pix)
   );

   assign rsp_bus.out_red   = out_pix[0];
   assign rsp_bus.out_green = out_pix[1];
   assign rsp_bus.out_blue  = out_pix[2];
   assign rsp_bus.out_alpha = out_pix[3];

`ifndef NO_ASSERTIONS
   // no new pixel is taken while a result is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_bus.valid && req_bus.ready))
      else $error("input accepted while a result is pending");

   // the closing result of a transaction frees the input side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.last |=> req_bus.ready)
      else $error("input not ready after final result");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.level != '0 && 32'(rsp_bus.level) < MAX_LEVELS))
      else $error("result level out of range");
`endif

endmodule

`default_nettype wire
